@@ src/scf_pkg.sv @@
package scf_pkg;

  localparam int STICK_W     = 12;
  localparam int WORD_W      = 16;
  localparam int BYTE_W      = 8;
  localparam int NUM_STICKS  = 4;
  localparam int SUM_W       = 18;
  localparam int MAG_W       = SUM_W - 1;
  localparam int STICK_CENTRE = 2048;
  localparam int STICK_FULL  = 4095;

  localparam int PEER_W      = 24;
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_IDX_W   = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_PEER_ADDR_TAIL  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTRA_FLAG_BYTE = 1'd1;

  localparam int IDX_W = 4;
  localparam logic [IDX_W-1:0] BYTE_PEER3    = 4'd0;
  localparam logic [IDX_W-1:0] BYTE_PEER4    = 4'd1;
  localparam logic [IDX_W-1:0] BYTE_PEER5    = 4'd2;
  localparam logic [IDX_W-1:0] BYTE_THR_LO   = 4'd3;
  localparam logic [IDX_W-1:0] BYTE_THR_HI   = 4'd4;
  localparam logic [IDX_W-1:0] BYTE_ROLL_LO  = 4'd5;
  localparam logic [IDX_W-1:0] BYTE_ROLL_HI  = 4'd6;
  localparam logic [IDX_W-1:0] BYTE_PITCH_LO = 4'd7;
  localparam logic [IDX_W-1:0] BYTE_PITCH_HI = 4'd8;
  localparam logic [IDX_W-1:0] BYTE_YAW_LO   = 4'd9;
  localparam logic [IDX_W-1:0] BYTE_YAW_HI   = 4'd10;
  localparam logic [IDX_W-1:0] BYTE_FLAGS    = 4'd11;
  localparam logic [IDX_W-1:0] BYTE_EXTRA    = 4'd12;
  localparam logic [IDX_W-1:0] BYTE_CSUM     = 4'd13;

  typedef enum logic [1:0] {
    PH_ACCUM,
    PH_DIVIDE,
    PH_ADJUST
  } lane_phase_t;

  typedef struct packed {
    logic        load;
    lane_phase_t phase;
  } lane_ctrl_t;

  typedef struct packed {
    logic                                valid;
    logic [NUM_STICKS-1:0][WORD_W-1:0]   words;
    logic [BYTE_W-1:0]                   flags;
  } pkt_req_t;

endpackage

@@ src/scf_in_if.sv @@
interface scf_in_if;
  logic                          valid;
  logic                          ready;
  logic [scf_pkg::STICK_W-1:0]   throttle_sample;
  logic [scf_pkg::STICK_W-1:0]   roll_raw;
  logic [scf_pkg::STICK_W-1:0]   pitch_raw;
  logic [scf_pkg::STICK_W-1:0]   yaw_raw;
  logic                          mode_button;
  logic                          option_button;
  logic                          flip_button;
  logic                          arm_button;

  modport source (
    output valid, throttle_sample, roll_raw, pitch_raw, yaw_raw,
           mode_button, option_button, flip_button, arm_button,
    input  ready
  );
  modport sink (
    input  valid, throttle_sample, roll_raw, pitch_raw, yaw_raw,
           mode_button, option_button, flip_button, arm_button,
    output ready
  );
endinterface

@@ src/scf_out_if.sv @@
interface scf_out_if;
  logic                        valid;
  logic                        ready;
  logic [scf_pkg::BYTE_W-1:0]  packet_byte;
  logic                        last_byte;

  modport source (output valid, packet_byte, last_byte, input ready);
  modport sink (input valid, packet_byte, last_byte, output ready);
endinterface

@@ src/scf_lane.sv @@
module scf_lane #(
  parameter int CAL_SAMPLES = 50,
  parameter bit INVERT      = 1'b0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  scf_pkg::lane_ctrl_t           ctrl,
  input  logic [scf_pkg::STICK_W-1:0]   raw,
  output logic [scf_pkg::WORD_W-1:0]    word_r
);

  localparam int SUM_W   = scf_pkg::SUM_W;
  localparam int MAG_W   = scf_pkg::MAG_W;
  localparam int WORD_W  = scf_pkg::WORD_W;
  localparam int SHIFT_L = $clog2(CAL_SAMPLES);
  localparam int K       = MAG_W + SHIFT_L;
  localparam int RECIP_W = MAG_W + 1;
  localparam int PROD_W  = MAG_W + RECIP_W;
  localparam longint unsigned RECIP =
    ((64'd1 << K) + longint'(CAL_SAMPLES) - 64'd1) / longint'(CAL_SAMPLES);

  logic signed [SUM_W-1:0]  bias_r, bias_nxt;
  logic [WORD_W-1:0]        word_nxt;
  logic signed [SUM_W-1:0]  raw_s;
  logic signed [SUM_W-1:0]  diff;
  logic [MAG_W-1:0]         mag;
  logic [RECIP_W-1:0]       recip;
  logic [PROD_W-1:0]        prod;
  logic [PROD_W-1:0]        shifted;
  logic [MAG_W-1:0]         quot;
  logic [WORD_W-1:0]        value;

  assign raw_s   = $signed({{(SUM_W-scf_pkg::STICK_W){1'b0}}, raw});
  assign diff    = raw_s - bias_r;
  assign recip   = RECIP_W'(RECIP);
  // Divide the magnitude by reciprocal multiply; exact for every sum in range.
  assign mag     = bias_r[SUM_W-1] ? MAG_W'(-bias_r) : MAG_W'(bias_r);
  assign prod    = PROD_W'(mag) * PROD_W'(recip);
  assign shifted = prod >> K;
  assign quot    = shifted[MAG_W-1:0];

  always_comb begin
    bias_nxt = bias_r;
    value    = WORD_W'(raw);
    unique case (ctrl.phase)
      scf_pkg::PH_ACCUM: begin
        bias_nxt = bias_r + raw_s - SUM_W'(scf_pkg::STICK_CENTRE);
      end
      scf_pkg::PH_DIVIDE: begin
        bias_nxt = bias_r[SUM_W-1] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
      end
      scf_pkg::PH_ADJUST: begin
        // clamp to zero below the bias
        value = (raw_s < bias_r) ? '0 : diff[WORD_W-1:0];
      end
      default: begin
        value = WORD_W'(raw);
      end
    endcase
    word_nxt = INVERT ? (WORD_W'(scf_pkg::STICK_FULL) - value) : value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_r <= '0;
    end else if (ctrl.load) begin
      bias_r <= bias_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      word_r <= word_nxt;
    end
  end

endmodule

@@ src/scf_framer.sv @@
module scf_framer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  scf_pkg::pkt_req_t             pkt,
  input  logic [scf_pkg::PEER_W-1:0]    peer_addr_tail,
  input  logic [scf_pkg::BYTE_W-1:0]    extra_flag_byte,
  output logic                          pkt_take,
  scf_out_if.source                     out_ch
);

  localparam int BYTE_W = scf_pkg::BYTE_W;
  localparam int IDX_W  = scf_pkg::IDX_W;

  logic                                                  busy_r, busy_nxt;
  logic [IDX_W-1:0]                                      idx_r, idx_nxt;
  logic [BYTE_W-1:0]                                     csum_r, csum_nxt;
  logic [scf_pkg::NUM_STICKS-1:0][scf_pkg::WORD_W-1:0]   words_r;
  logic [BYTE_W-1:0]                                     flags_r;
  logic                                                  out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]                                     out_byte_r;
  logic                                                  out_last_r;
  logic                                                  out_load;
  logic                                                  at_last;
  logic [BYTE_W-1:0]                                     byte_sel;

  assign out_load = busy_r && (!out_valid_r || out_ch.ready);
  assign at_last  = (idx_r == scf_pkg::BYTE_CSUM);
  assign pkt_take = pkt.valid && (!busy_r || (out_load && at_last));

  always_comb begin
    unique case (idx_r)
      scf_pkg::BYTE_PEER3:    byte_sel = peer_addr_tail[23:16];
      scf_pkg::BYTE_PEER4:    byte_sel = peer_addr_tail[15:8];
      scf_pkg::BYTE_PEER5:    byte_sel = peer_addr_tail[7:0];
      scf_pkg::BYTE_THR_LO:   byte_sel = words_r[0][7:0];
      scf_pkg::BYTE_THR_HI:   byte_sel = words_r[0][15:8];
      scf_pkg::BYTE_ROLL_LO:  byte_sel = words_r[1][7:0];
      scf_pkg::BYTE_ROLL_HI:  byte_sel = words_r[1][15:8];
      scf_pkg::BYTE_PITCH_LO: byte_sel = words_r[2][7:0];
      scf_pkg::BYTE_PITCH_HI: byte_sel = words_r[2][15:8];
      scf_pkg::BYTE_YAW_LO:   byte_sel = words_r[3][7:0];
      scf_pkg::BYTE_YAW_HI:   byte_sel = words_r[3][15:8];
      scf_pkg::BYTE_FLAGS:    byte_sel = flags_r;
      scf_pkg::BYTE_EXTRA:    byte_sel = extra_flag_byte;
      scf_pkg::BYTE_CSUM:     byte_sel = csum_r;
      default:                byte_sel = csum_r;
    endcase
  end

  always_comb begin
    busy_nxt      = busy_r;
    idx_nxt       = idx_r;
    csum_nxt      = csum_r;
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = idx_r + 1'b1;
      csum_nxt      = csum_r + byte_sel;
      if (at_last) begin
        busy_nxt = 1'b0;
      end
    end
    if (pkt_take) begin
      busy_nxt = 1'b1;
      idx_nxt  = scf_pkg::BYTE_PEER3;
      csum_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= scf_pkg::BYTE_PEER3;
      csum_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      csum_r      <= csum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pkt_take) begin
      words_r <= pkt.words;
      flags_r <= pkt.flags;
    end
    if (out_load) begin
      out_byte_r <= byte_sel;
      out_last_r <= at_last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.packet_byte = out_byte_r;
  assign out_ch.last_byte   = out_last_r;

endmodule

@@ src/stick_calibrate_and_packet_framer.sv @@
// Stick calibration and control packet framer.
//
// in_ch (valid/ready): one request per stick sample, carrying four 12-bit
//   stick values and four button levels. A request is taken when valid and
//   ready are both high at a rising edge of clk.
// out_ch (valid/ready): 14 bytes per sample, byte 0 first; last_byte marks
//   byte 13, the byte-sum checksum that ends the packet.
// cfg_we/cfg_index/cfg_wdata: write the peer address tail (index 0) and the
//   extra flag byte (index 1); write only while no packet is in flight.
// A taken request passes the packet stage, the framer registers and the output
//   register before its first byte shows on out_ch; the remaining bytes follow
//   one per cycle while out_ch is ready, through the single byte-wide output
//   register. A sample request is taken while the previous packet is still
//   streaming out; one finished sample waits in the packet stage.
// Four stick lanes run side by side; the framer merges their words.
// Reset (rst_n low, synchronous) clears the sample count, bias sums, mode
//   bits and config registers and drops any partial packet.
// When out_ch stalls, hold the current byte; once the packet stage fills,
//   in_ch ready drops until the framer takes the waiting sample.
module stick_calibrate_and_packet_framer #(
  parameter int CAL_SAMPLES = 50
) (
  input  logic                              clk,
  input  logic                              rst_n,
  scf_in_if.sink                            in_ch,
  scf_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [scf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [scf_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int CNT_W = $clog2(CAL_SAMPLES + 2);
  localparam int NUM_STICKS = scf_pkg::NUM_STICKS;

  logic [CNT_W-1:0]                 count_r, count_nxt;
  logic                             ctl_mode_r, ctl_mode_nxt;
  logic                             alt_mode_r, alt_mode_nxt;
  logic                             mode_prev_r, opt_prev_r;
  logic                             pkt_valid_r, pkt_valid_nxt;
  logic [scf_pkg::BYTE_W-1:0]       flags_r;
  logic [scf_pkg::PEER_W-1:0]       peer_r;
  logic [scf_pkg::BYTE_W-1:0]       extra_r;
  logic                             accept;
  logic                             pkt_take;
  scf_pkg::lane_ctrl_t              lane_ctrl;
  scf_pkg::pkt_req_t                pkt;
  logic [NUM_STICKS-1:0][scf_pkg::STICK_W-1:0] raw;
  logic [NUM_STICKS-1:0][scf_pkg::WORD_W-1:0]  words;

  // The packet stage frees up in the same cycle the framer takes it.
  assign in_ch.ready = !pkt_valid_r || pkt_take;
  assign accept      = in_ch.valid && in_ch.ready;

  assign raw[0] = in_ch.throttle_sample;
  assign raw[1] = in_ch.roll_raw;
  assign raw[2] = in_ch.pitch_raw;
  assign raw[3] = in_ch.yaw_raw;

  always_comb begin
    lane_ctrl.load = accept;
    priority if (count_r < CNT_W'(CAL_SAMPLES)) begin
      lane_ctrl.phase = scf_pkg::PH_ACCUM;
    end else if (count_r == CNT_W'(CAL_SAMPLES)) begin
      lane_ctrl.phase = scf_pkg::PH_DIVIDE;
    end else begin
      lane_ctrl.phase = scf_pkg::PH_ADJUST;
    end
  end

  // Mode bits toggle on rising button edges; the new value goes in this packet.
  always_comb begin
    count_nxt     = count_r;
    ctl_mode_nxt  = ctl_mode_r ^ (in_ch.mode_button & ~mode_prev_r);
    alt_mode_nxt  = alt_mode_r ^ (in_ch.option_button & ~opt_prev_r);
    pkt_valid_nxt = pkt_valid_r;
    if (pkt_take) begin
      pkt_valid_nxt = 1'b0;
    end
    if (accept) begin
      pkt_valid_nxt = 1'b1;
      // Advance through calibration, then park one past the sample budget.
      if (count_r <= CNT_W'(CAL_SAMPLES)) begin
        count_nxt = count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ctl_mode_r  <= 1'b0;
      alt_mode_r  <= 1'b0;
      mode_prev_r <= 1'b0;
      opt_prev_r  <= 1'b0;
      pkt_valid_r <= 1'b0;
    end else begin
      pkt_valid_r <= pkt_valid_nxt;
      if (accept) begin
        count_r     <= count_nxt;
        ctl_mode_r  <= ctl_mode_nxt;
        alt_mode_r  <= alt_mode_nxt;
        mode_prev_r <= in_ch.mode_button;
        opt_prev_r  <= in_ch.option_button;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      flags_r <= {4'b0000, alt_mode_nxt, ctl_mode_nxt, in_ch.flip_button, in_ch.arm_button};
    end
  end

  // Configuration registers; ignore indexes that name nothing.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peer_r  <= '0;
      extra_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        scf_pkg::CFG_PEER_ADDR_TAIL:  peer_r  <= cfg_wdata[scf_pkg::PEER_W-1:0];
        scf_pkg::CFG_EXTRA_FLAG_BYTE: extra_r <= cfg_wdata[scf_pkg::BYTE_W-1:0];
        default: begin
          peer_r <= peer_r;
        end
      endcase
    end
  end

  // One lane per stick; the throttle lane inverts its word.
  for (genvar g = 0; g < NUM_STICKS; g++) begin : g_lane
    scf_lane #(
      .CAL_SAMPLES (CAL_SAMPLES),
      .INVERT      (g == 0)
    ) u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl   (lane_ctrl),
      .raw    (raw[g]),
      .word_r (words[g])
    );
  end

  assign pkt.valid = pkt_valid_r;
  assign pkt.words = words;
  assign pkt.flags = flags_r;

  scf_framer u_framer (
    .clk             (clk),
    .rst_n           (rst_n),
    .pkt             (pkt),
    .peer_addr_tail  (peer_r),
    .extra_flag_byte (extra_r),
    .pkt_take        (pkt_take),
    .out_ch          (out_ch)
  );

endmodule

@@ sim/stick_calibrate_and_packet_framer_checker.sv @@
`timescale 1ns / 100ps

module stick_calibrate_and_packet_framer_checker #(
  parameter int CAL_SAMPLES = 50
) (
  input  logic                            clk,
  input  logic                            rst_n,
  scf_in_if                               in_ch,
  scf_out_if                              out_ch,
  input  logic                            cfg_we,
  input  logic [scf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [scf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output int                              mismatches,
  output int                              pending
);

  localparam int PKT_LEN    = scf_pkg::BYTE_CSUM + 1;
  localparam int MAX_LOGS   = 10;
  localparam int BYTE_W     = scf_pkg::BYTE_W;
  localparam int WORD_W     = scf_pkg::WORD_W;
  localparam int PEER_W     = scf_pkg::PEER_W;
  localparam int NUM_STICKS = scf_pkg::NUM_STICKS;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } pkt_byte_t;

  pkt_byte_t         expected_bytes [$];
  int                fail_count = 0;
  int                backlog = 0;

  logic [PEER_W-1:0] peer_tail;
  logic [BYTE_W-1:0] extra_byte;
  int                cal_count;
  int                bias_acc [NUM_STICKS];
  logic              ctrl_mode;
  logic              alt_mode;
  logic              mode_prev;
  logic              option_prev;

  assign mismatches = fail_count;
  assign pending    = backlog;

  // Advance the calibration state and queue the 14 bytes of one sample packet.
  task automatic frame_packet();
    int                raw [NUM_STICKS];
    logic [WORD_W-1:0] word [NUM_STICKS];
    logic [BYTE_W-1:0] pkt [PKT_LEN];
    logic [BYTE_W-1:0] csum;
    raw[0] = int'(in_ch.throttle_sample);
    raw[1] = int'(in_ch.roll_raw);
    raw[2] = int'(in_ch.pitch_raw);
    raw[3] = int'(in_ch.yaw_raw);

    if (in_ch.mode_button && !mode_prev) ctrl_mode = ~ctrl_mode;
    mode_prev = in_ch.mode_button;
    if (in_ch.option_button && !option_prev) alt_mode = ~alt_mode;
    option_prev = in_ch.option_button;

    if (cal_count < CAL_SAMPLES) begin
      cal_count++;
      for (int i = 0; i < NUM_STICKS; i++)
        bias_acc[i] += raw[i] - scf_pkg::STICK_CENTRE;
    end else if (cal_count == CAL_SAMPLES) begin
      cal_count++;
      for (int i = 0; i < NUM_STICKS; i++) bias_acc[i] = bias_acc[i] / CAL_SAMPLES;
    end else begin
      for (int i = 0; i < NUM_STICKS; i++)
        raw[i] = (raw[i] < bias_acc[i]) ? 0 : raw[i] - bias_acc[i];
    end

    word[0] = WORD_W'(scf_pkg::STICK_FULL - raw[0]);
    for (int i = 1; i < NUM_STICKS; i++) word[i] = WORD_W'(raw[i]);

    pkt[scf_pkg::BYTE_PEER3] = peer_tail[23:16];
    pkt[scf_pkg::BYTE_PEER4] = peer_tail[15:8];
    pkt[scf_pkg::BYTE_PEER5] = peer_tail[7:0];
    for (int i = 0; i < NUM_STICKS; i++) begin
      pkt[scf_pkg::BYTE_THR_LO + 2 * i] = word[i][7:0];
      pkt[scf_pkg::BYTE_THR_HI + 2 * i] = word[i][15:8];
    end
    pkt[scf_pkg::BYTE_FLAGS] = {4'b0000, alt_mode, ctrl_mode,
                                in_ch.flip_button, in_ch.arm_button};
    pkt[scf_pkg::BYTE_EXTRA] = extra_byte;
    csum = '0;
    for (int i = 0; i < scf_pkg::BYTE_CSUM; i++) csum += pkt[i];
    pkt[scf_pkg::BYTE_CSUM] = csum;

    for (int i = 0; i < PKT_LEN; i++)
      expected_bytes.push_back('{data: pkt[i], last: (i == scf_pkg::BYTE_CSUM)});
  endtask

  task automatic log_mismatch(input string what, input pkt_byte_t want);
    fail_count++;
    if (fail_count <= MAX_LOGS)
      $display("%0t: %s: expected byte=%02h last=%b, got byte=%02h last=%b",
               $realtime, what, want.data, want.last, out_ch.packet_byte, out_ch.last_byte);
  endtask

  task automatic check_byte();
    pkt_byte_t want;
    if (expected_bytes.size() == 0) begin
      want = '0;
      log_mismatch("packet byte with nothing outstanding", want);
    end else begin
      want = expected_bytes.pop_front();
      if (out_ch.packet_byte !== want.data || out_ch.last_byte !== want.last)
        log_mismatch("packet byte mismatch", want);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      peer_tail   = '0;
      extra_byte  = '0;
      cal_count   = 0;
      for (int i = 0; i < NUM_STICKS; i++) bias_acc[i] = 0;
      ctrl_mode   = 1'b0;
      alt_mode    = 1'b0;
      mode_prev   = 1'b0;
      option_prev = 1'b0;
      expected_bytes.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          scf_pkg::CFG_PEER_ADDR_TAIL:  peer_tail  = cfg_wdata[PEER_W-1:0];
          scf_pkg::CFG_EXTRA_FLAG_BYTE: extra_byte = cfg_wdata[BYTE_W-1:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) check_byte();
      if (in_ch.valid && in_ch.ready) frame_packet();
    end
    backlog = expected_bytes.size();
  end

endmodule

@@ sim/stick_calibrate_and_packet_framer_tb.sv @@
`timescale 1ns / 100ps

module stick_calibrate_and_packet_framer_tb;

  localparam int CAL_SAMPLES    = 50;
  localparam int RESET_CYCLES   = 7;
  localparam int RANDOM_PHASES  = 4;
  localparam int PHASE_ITEMS    = 95;
  localparam int SETTLE_CYCLES  = 20;
  localparam int HOLD_CYCLES    = 300;
  localparam int QUIET_LIMIT    = 5000;
  localparam int IDLE_PCT       = 35;
  localparam int RX_STRETCH     = 600;
  localparam int STICK_W        = scf_pkg::STICK_W;
  localparam int PEER_W         = scf_pkg::PEER_W;
  localparam int BYTE_W         = scf_pkg::BYTE_W;
  localparam int CFG_DATA_W     = scf_pkg::CFG_DATA_W;

  typedef struct packed {
    logic [STICK_W-1:0] throttle;
    logic [STICK_W-1:0] roll;
    logic [STICK_W-1:0] pitch;
    logic [STICK_W-1:0] yaw;
    logic               mode;
    logic               option;
    logic               flip;
    logic               arm;
  } sample_t;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_we;
  logic [scf_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0]          cfg_wdata;
  int                             mismatches;
  int                             pending;
  int                             quiet_cycles = 0;

  // Stimulus to receiver hints: sender gaps on/off, and a one-shot long hold.
  bit                    sender_idles = 1'b1;
  bit                    hold_req = 1'b0;
  sample_t               sample_q [$];

  scf_in_if  sample_if ();
  scf_out_if pkt_if ();

  always #5 clk = ~clk;

  stick_calibrate_and_packet_framer #(.CAL_SAMPLES(CAL_SAMPLES)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (sample_if),
    .out_ch    (pkt_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  stick_calibrate_and_packet_framer_checker #(.CAL_SAMPLES(CAL_SAMPLES)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (sample_if),
    .out_ch     (pkt_if),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // Buttons packed as {mode, option, flip, arm}.
  function automatic sample_t make_sample(input logic [STICK_W-1:0] thr, roll, pitch, yaw,
                                          input logic [3:0] btn);
    return '{throttle: thr, roll: roll, pitch: pitch, yaw: yaw,
             mode: btn[3], option: btn[2], flip: btn[1], arm: btn[0]};
  endfunction

  // Favor the rails and small values: small values sit near the yaw and pitch
  // biases, so the clamp-to-zero path gets hit often.
  function automatic logic [STICK_W-1:0] random_stick();
    int pick;
    pick = $urandom_range(99);
    if (pick < 15) return ($urandom_range(1) != 0) ? {STICK_W{1'b1}} : '0;
    if (pick < 40) return STICK_W'($urandom_range(300));
    return STICK_W'($urandom);
  endfunction

  // Write both registers back to back; only call while nothing is in flight.
  // Junk in the upper data bits of the byte register must be dropped.
  task automatic load_settings(input logic [PEER_W-1:0] peer, input logic [BYTE_W-1:0] extra);
    cfg_we    <= 1'b1;
    cfg_index <= scf_pkg::CFG_PEER_ADDR_TAIL;
    cfg_wdata <= CFG_DATA_W'(peer);
    @(posedge clk);
    cfg_index <= scf_pkg::CFG_EXTRA_FLAG_BYTE;
    cfg_wdata <= {(CFG_DATA_W - BYTE_W)'($urandom), extra};
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Offer every queued request in order; insert random gaps when asked.
  // Exactly one assignment to valid per edge, so no lower/raise collisions.
  task automatic play_samples();
    bit gap;
    while (sample_q.size() != 0) begin
      gap = sender_idles && ($urandom_range(99) < IDLE_PCT);
      if (gap) begin
        sample_if.valid <= 1'b0;
      end else begin
        sample_if.valid           <= 1'b1;
        sample_if.throttle_sample <= sample_q[0].throttle;
        sample_if.roll_raw        <= sample_q[0].roll;
        sample_if.pitch_raw       <= sample_q[0].pitch;
        sample_if.yaw_raw         <= sample_q[0].yaw;
        sample_if.mode_button     <= sample_q[0].mode;
        sample_if.option_button   <= sample_q[0].option;
        sample_if.flip_button     <= sample_q[0].flip;
        sample_if.arm_button      <= sample_q[0].arm;
      end
      @(posedge clk);
      if (!gap) begin
        while (!sample_if.ready) @(posedge clk);
        void'(sample_q.pop_front());
      end
    end
    sample_if.valid <= 1'b0;
  endtask

  // Wait for every expected byte, then let the pipeline settle.
  task automatic drain();
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Receiver: random stalls, a periodic stretch with no stalls at all, and one
  // long hold (counted here) so the packet stage fills and in_ch ready drops.
  initial begin : receiver
    int  cyc;
    int  hold_left;
    bit  hold_taken;
    cyc        = 0;
    hold_left  = 0;
    hold_taken = 1'b0;
    pkt_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pkt_if.ready <= 1'b0;
      end else if ((cyc / RX_STRETCH) % 3 == 2) begin
        pkt_if.ready <= 1'b1;
      end else begin
        pkt_if.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog: restart on any request, any packet byte or any register write.
  always @(posedge clk) begin
    if (!rst_n || (sample_if.valid && sample_if.ready) || (pkt_if.valid && pkt_if.ready) ||
        cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("stick_calibrate_and_packet_framer test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    rst_n                     <= 1'b0;
    cfg_we                    <= 1'b0;
    cfg_index                 <= scf_pkg::CFG_PEER_ADDR_TAIL;
    cfg_wdata                 <= '0;
    sample_if.valid           <= 1'b0;
    sample_if.throttle_sample <= '0;
    sample_if.roll_raw        <= '0;
    sample_if.pitch_raw       <= '0;
    sample_if.yaw_raw         <= '0;
    sample_if.mode_button     <= 1'b0;
    sample_if.option_button   <= 1'b0;
    sample_if.flip_button     <= 1'b0;
    sample_if.arm_button      <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Calibration window plus the divide sample. Pin throttle to 0 and roll to
    // full scale for the extreme biases (-2048 and +2047); keep pitch just below
    // centre so its sum is negative and the divide has to truncate toward zero;
    // keep yaw just above centre for a small positive bias.
    load_settings({PEER_W{1'b1}}, 8'h00);
    for (int n = 0; n <= CAL_SAMPLES; n++)
      sample_q.push_back(make_sample('0, {STICK_W{1'b1}},
                                     STICK_W'($urandom_range(1900, 2047)),
                                     STICK_W'($urandom_range(2049, 2300)),
                                     4'($urandom)));
    play_samples();
    drain();

    // Directed: rails, every button alone and together, and the roll clamp edge.
    load_settings('0, 8'hFF);
    sample_q.push_back(make_sample(12'h000, 12'h000, 12'h000, 12'h000, 4'b0000));
    sample_q.push_back(make_sample(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 4'b1111));
    sample_q.push_back(make_sample(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 4'b1111));
    sample_q.push_back(make_sample(12'h000, 12'hFFF, 12'h000, 12'hFFF, 4'b0000));
    sample_q.push_back(make_sample(12'h800, 12'h800, 12'h800, 12'h800, 4'b1000));
    sample_q.push_back(make_sample(12'h800, 12'h800, 12'h800, 12'h800, 4'b0100));
    sample_q.push_back(make_sample(12'h800, 12'h800, 12'h800, 12'h800, 4'b0010));
    sample_q.push_back(make_sample(12'h800, 12'h800, 12'h800, 12'h800, 4'b0001));
    sample_q.push_back(make_sample(12'h800, 12'h7FF, 12'h000, 12'h001, 4'b1100));
    sample_q.push_back(make_sample(12'h800, 12'h7FE, 12'h001, 12'h000, 4'b0000));
    sample_q.push_back(make_sample(12'h800, 12'h800, 12'h7FF, 12'h07F, 4'b0100));
    sample_q.push_back(make_sample(12'hAAA, 12'h555, 12'hAAA, 12'h555, 4'b1010));
    sample_q.push_back(make_sample(12'h555, 12'hAAA, 12'h555, 12'hAAA, 4'b0101));
    sample_q.push_back(make_sample(12'hFFF, 12'h000, 12'hFFF, 12'h000, 4'b1111));
    play_samples();
    drain();

    // Random phases: new settings each time, finishing on the all-ones extremes.
    // Phase 1 drops sender gaps; phase 2 triggers the long receiver hold.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == RANDOM_PHASES - 1) load_settings({PEER_W{1'b1}}, 8'hFF);
      else load_settings(PEER_W'($urandom), BYTE_W'($urandom));
      sender_idles = (ph != 1);
      if (ph == 2) hold_req = 1'b1;
      repeat (PHASE_ITEMS)
        sample_q.push_back(make_sample(random_stick(), random_stick(), random_stick(),
                                       random_stick(), 4'($urandom)));
      play_samples();
      drain();
    end

    if (mismatches == 0) begin
      $display("stick_calibrate_and_packet_framer test passed");
    end else begin
      $display("stick_calibrate_and_packet_framer test failed");
    end
    $finish;
  end

endmodule
